// ----- rtl/core/pfp_pkg.sv -----
// shared constants and types for the preamble frame parser
`default_nettype none

package pfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int CRC_W       = 16;
    localparam int LEN_W       = 16;
    localparam int CNT_OUT_W   = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int HEADER_BYTES = 5;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_OK      = 2'd1,
        KIND_CRC_ERR = 2'd2,
        KIND_LEN_ERR = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PREAMBLE = 2'd0,
        REG_MAX_LEN  = 2'd1,
        REG_CRC_POLY = 2'd2,
        REG_CRC_INIT = 2'd3
    } t_reg_idx;

    localparam logic [CFG_DATA_W-1:0] RST_PREAMBLE = 16'hAA55;
    localparam logic [CFG_DATA_W-1:0] RST_MAX_LEN  = 16'd512;
    localparam logic [CFG_DATA_W-1:0] RST_CRC_POLY = 16'h1021;
    localparam logic [CFG_DATA_W-1:0] RST_CRC_INIT = 16'hFFFF;

endpackage

`default_nettype wire

// ----- rtl/core/pfp_crc16.sv -----
// byte-wide msb-first crc16 update with programmable polynomial
`default_nettype none

module pfp_crc16 (
    input  logic [pfp_pkg::CRC_W-1:0]  i_crc,
    input  logic [pfp_pkg::BYTE_W-1:0] i_byte,
    input  logic [pfp_pkg::CRC_W-1:0]  i_poly,
    output logic [pfp_pkg::CRC_W-1:0]  o_crc
);
    import pfp_pkg::*;

    logic [CRC_W-1:0] w_crc;

    // eight shift steps, one per data bit
    always_comb begin
        w_crc = i_crc ^ {i_byte, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            if (w_crc[CRC_W-1]) begin
                w_crc = {w_crc[CRC_W-2:0], 1'b0} ^ i_poly;
            end else begin
                w_crc = {w_crc[CRC_W-2:0], 1'b0};
            end
        end
    end

    assign o_crc = w_crc;

endmodule

`default_nettype wire

// ----- rtl/core/preamble_frame_parser_crc16_unit.sv -----
// Latency: a result word is valid in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle while o_stall is low, set by the byte-wide crc update and parser step.
// A waiting result does not block input unless the output is stalled while full.
// Reset: synchronous, active low; registers return to defaults, counters clear,
// the parser goes back to preamble search and the output word is dropped.
`default_nettype none

module preamble_frame_parser_crc16_unit #(
    parameter int PREAMBLE_BYTES_N = 2,
    parameter int COUNTER_BITS     = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [pfp_pkg::BYTE_W-1:0]      i_rx_byte,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [1:0]                      o_result_kind,
    output logic [pfp_pkg::BYTE_W-1:0]      o_data_byte,
    output logic [pfp_pkg::LEN_W-1:0]       o_payload_index,
    output logic [pfp_pkg::BYTE_W-1:0]      o_frame_version,
    output logic [pfp_pkg::BYTE_W-1:0]      o_frame_type,
    output logic [pfp_pkg::BYTE_W-1:0]      o_frame_seq,
    output logic [pfp_pkg::LEN_W-1:0]       o_frame_length,
    output logic [pfp_pkg::CRC_W-1:0]       o_received_crc,
    output logic [pfp_pkg::CNT_OUT_W-1:0]   o_ok_frames,
    output logic [pfp_pkg::CNT_OUT_W-1:0]   o_crc_failures,
    output logic [pfp_pkg::CNT_OUT_W-1:0]   o_length_failures,
    input  logic                            i_cfg_we,
    input  logic [pfp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pfp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pfp_pkg::*;

    localparam int SC_W = (PREAMBLE_BYTES_N > 1) ? $clog2(PREAMBLE_BYTES_N) : 1;

    typedef enum logic [1:0] {
        PH_SYNC    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CRC     = 2'd3
    } t_phase;

    // configuration
    logic [CFG_DATA_W-1:0] r_preamble, r_max_len, r_crc_poly, r_crc_init;

    // parser state
    t_phase                r_phase, n_phase;
    logic [SC_W-1:0]       r_sync_count, n_sync_count;
    logic [LEN_W-1:0]      r_byte_count, n_byte_count;
    logic [BYTE_W-1:0]     r_hdr_version, n_hdr_version;
    logic [BYTE_W-1:0]     r_hdr_type, n_hdr_type;
    logic [BYTE_W-1:0]     r_hdr_seq, n_hdr_seq;
    logic [LEN_W-1:0]      r_hdr_length, n_hdr_length;
    logic [CRC_W-1:0]      r_crc_rx, n_crc_rx;
    logic [CRC_W-1:0]      r_crc_run, n_crc_run;
    logic [COUNTER_BITS-1:0] r_cnt_ok, n_cnt_ok;
    logic [COUNTER_BITS-1:0] r_cnt_crc, n_cnt_crc;
    logic [COUNTER_BITS-1:0] r_cnt_len, n_cnt_len;

    // output word
    logic                  r_out_valid, n_out_valid;
    t_kind                 r_kind;
    logic [BYTE_W-1:0]     r_data;
    logic [LEN_W-1:0]      r_idx;
    logic [BYTE_W-1:0]     r_version, r_type, r_seq;
    logic [LEN_W-1:0]      r_length;
    logic [CRC_W-1:0]      r_rcrc;
    logic [CNT_OUT_W-1:0]  r_ok_out, r_crc_out, r_len_out;

    logic                  w_accept;
    logic                  w_has_res;
    t_kind                 w_kind;
    logic [BYTE_W-1:0]     w_data;
    logic [LEN_W-1:0]      w_idx;
    logic [CRC_W-1:0]      w_rcrc;
    logic [CRC_W-1:0]      w_crc_in, w_crc_out;
    logic [BYTE_W-1:0]     w_pre_byte, w_pre_first;
    logic [SC_W:0]         w_sync_inc;
    logic [LEN_W-1:0]      w_bc_inc;
    logic [CRC_W-1:0]      w_rc_full;
    logic [CNT_OUT_W-1:0]  w_ok_ext, w_crc_ext, w_len_ext;

    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;

    // first header byte restarts the crc from the programmed seed
    assign w_crc_in = (r_phase == PH_HEADER && r_byte_count == '0) ? r_crc_init : r_crc_run;

    pfp_crc16 u_crc (
        .i_crc  (w_crc_in),
        .i_byte (i_rx_byte),
        .i_poly (r_crc_poly),
        .o_crc  (w_crc_out)
    );

    assign w_pre_first = r_preamble[CFG_DATA_W-1 -: BYTE_W];
    assign w_sync_inc  = {1'b0, r_sync_count} + {{SC_W{1'b0}}, 1'b1};
    assign w_bc_inc    = r_byte_count + {{(LEN_W-1){1'b0}}, 1'b1};
    assign w_rc_full   = r_crc_rx | {{(CRC_W-BYTE_W){1'b0}}, i_rx_byte};

    // only the first two preamble bytes are programmable, the rest are zero
    always_comb begin
        if (r_sync_count == SC_W'(0)) begin
            w_pre_byte = w_pre_first;
        end else if (r_sync_count == SC_W'(1)) begin
            w_pre_byte = r_preamble[BYTE_W-1:0];
        end else begin
            w_pre_byte = '0;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_sync_count  = r_sync_count;
        n_byte_count  = r_byte_count;
        n_hdr_version = r_hdr_version;
        n_hdr_type    = r_hdr_type;
        n_hdr_seq     = r_hdr_seq;
        n_hdr_length  = r_hdr_length;
        n_crc_rx      = r_crc_rx;
        n_crc_run     = r_crc_run;
        n_cnt_ok      = r_cnt_ok;
        n_cnt_crc     = r_cnt_crc;
        n_cnt_len     = r_cnt_len;
        w_has_res     = 1'b0;
        w_kind        = KIND_PAYLOAD;
        w_data        = '0;
        w_idx         = '0;
        w_rcrc        = '0;

        unique case (r_phase)
            PH_SYNC: begin
                if (i_rx_byte == w_pre_byte) begin
                    if (w_sync_inc >= (SC_W+1)'(PREAMBLE_BYTES_N)) begin
                        n_phase      = PH_HEADER;
                        n_sync_count = '0;
                        n_byte_count = '0;
                    end else begin
                        n_sync_count = w_sync_inc[SC_W-1:0];
                    end
                end else if (i_rx_byte == w_pre_first) begin
                    n_sync_count = SC_W'(1);
                end else begin
                    n_sync_count = '0;
                end
            end
            PH_HEADER: begin
                case (r_byte_count)
                    16'd0:   n_hdr_version = i_rx_byte;
                    16'd1:   n_hdr_type    = i_rx_byte;
                    16'd2:   n_hdr_seq     = i_rx_byte;
                    16'd3:   n_hdr_length  = {i_rx_byte, {BYTE_W{1'b0}}};
                    default: n_hdr_length  = r_hdr_length
                                             | {{(LEN_W-BYTE_W){1'b0}}, i_rx_byte};
                endcase
                n_crc_run    = w_crc_out;
                n_byte_count = w_bc_inc;
                if (w_bc_inc >= LEN_W'(HEADER_BYTES)) begin
                    n_byte_count = '0;
                    if (n_hdr_length > r_max_len) begin
                        n_cnt_len = r_cnt_len + {{(COUNTER_BITS-1){1'b0}}, 1'b1};
                        n_phase   = PH_SYNC;
                        n_sync_count = '0;
                        n_crc_rx  = '0;
                        w_has_res = 1'b1;
                        w_kind    = KIND_LEN_ERR;
                    end else if (n_hdr_length != '0) begin
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_phase = PH_CRC;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_crc_run    = w_crc_out;
                n_byte_count = w_bc_inc;
                if (w_bc_inc >= r_hdr_length) begin
                    n_byte_count = '0;
                    n_phase      = PH_CRC;
                end
                w_has_res = 1'b1;
                w_kind    = KIND_PAYLOAD;
                w_data    = i_rx_byte;
                w_idx     = r_byte_count;
            end
            PH_CRC: begin
                if (r_byte_count == '0) begin
                    n_crc_rx     = {i_rx_byte, {BYTE_W{1'b0}}};
                    n_byte_count = {{(LEN_W-1){1'b0}}, 1'b1};
                end else begin
                    if (w_rc_full == r_crc_run) begin
                        n_cnt_ok = r_cnt_ok + {{(COUNTER_BITS-1){1'b0}}, 1'b1};
                        w_kind   = KIND_OK;
                    end else begin
                        n_cnt_crc = r_cnt_crc + {{(COUNTER_BITS-1){1'b0}}, 1'b1};
                        w_kind    = KIND_CRC_ERR;
                    end
                    n_phase      = PH_SYNC;
                    n_sync_count = '0;
                    n_byte_count = '0;
                    n_crc_rx     = '0;
                    w_has_res    = 1'b1;
                    w_rcrc       = w_rc_full;
                end
            end
            default: n_phase = PH_SYNC;
        endcase
    end

    // counters are reported as their low bits, zero-extended when narrower
    generate
        if (COUNTER_BITS >= CNT_OUT_W) begin : g_cnt_trunc
            assign w_ok_ext  = n_cnt_ok[CNT_OUT_W-1:0];
            assign w_crc_ext = n_cnt_crc[CNT_OUT_W-1:0];
            assign w_len_ext = n_cnt_len[CNT_OUT_W-1:0];
        end else begin : g_cnt_ext
            assign w_ok_ext  = {{(CNT_OUT_W-COUNTER_BITS){1'b0}}, n_cnt_ok};
            assign w_crc_ext = {{(CNT_OUT_W-COUNTER_BITS){1'b0}}, n_cnt_crc};
            assign w_len_ext = {{(CNT_OUT_W-COUNTER_BITS){1'b0}}, n_cnt_len};
        end
    endgenerate

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept && w_has_res) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preamble    <= RST_PREAMBLE;
            r_max_len     <= RST_MAX_LEN;
            r_crc_poly    <= RST_CRC_POLY;
            r_crc_init    <= RST_CRC_INIT;
            r_phase       <= PH_SYNC;
            r_sync_count  <= '0;
            r_byte_count  <= '0;
            r_hdr_version <= '0;
            r_hdr_type    <= '0;
            r_hdr_seq     <= '0;
            r_hdr_length  <= '0;
            r_crc_rx      <= '0;
            r_crc_run     <= RST_CRC_INIT;
            r_cnt_ok      <= '0;
            r_cnt_crc     <= '0;
            r_cnt_len     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_PREAMBLE: r_preamble <= i_cfg_data;
                    REG_MAX_LEN:  r_max_len  <= i_cfg_data;
                    REG_CRC_POLY: r_crc_poly <= i_cfg_data;
                    REG_CRC_INIT: r_crc_init <= i_cfg_data;
                    default:      r_preamble <= r_preamble;
                endcase
            end
            if (w_accept) begin
                r_phase       <= n_phase;
                r_sync_count  <= n_sync_count;
                r_byte_count  <= n_byte_count;
                r_hdr_version <= n_hdr_version;
                r_hdr_type    <= n_hdr_type;
                r_hdr_seq     <= n_hdr_seq;
                r_hdr_length  <= n_hdr_length;
                r_crc_rx      <= n_crc_rx;
                r_crc_run     <= n_crc_run;
                r_cnt_ok      <= n_cnt_ok;
                r_cnt_crc     <= n_cnt_crc;
                r_cnt_len     <= n_cnt_len;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // result word payload, loaded only when a new word is produced
    always_ff @(posedge i_clk) begin
        if (w_accept && w_has_res) begin
            r_kind    <= w_kind;
            r_data    <= w_data;
            r_idx     <= w_idx;
            r_version <= n_hdr_version;
            r_type    <= n_hdr_type;
            r_seq     <= n_hdr_seq;
            r_length  <= n_hdr_length;
            r_rcrc    <= w_rcrc;
            r_ok_out  <= w_ok_ext;
            r_crc_out <= w_crc_ext;
            r_len_out <= w_len_ext;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_result_kind     = r_kind;
    assign o_data_byte       = r_data;
    assign o_payload_index   = r_idx;
    assign o_frame_version   = r_version;
    assign o_frame_type      = r_type;
    assign o_frame_seq       = r_seq;
    assign o_frame_length    = r_length;
    assign o_received_crc    = r_rcrc;
    assign o_ok_frames       = r_ok_out;
    assign o_crc_failures    = r_crc_out;
    assign o_length_failures = r_len_out;

`ifndef SYNTHESIS
    a_new_word_from_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_accept))
        else $error("result word appeared without an accepted byte");

    // the limit may be rewritten mid-frame, so only the length itself is checked
    a_payload_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_hdr_length != '0))
        else $error("payload phase with an empty length");

    a_header_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_byte_count < LEN_W'(HEADER_BYTES)))
        else $error("header byte count out of range");

    a_crc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CRC) |-> (r_byte_count <= {{(LEN_W-1){1'b0}}, 1'b1}))
        else $error("crc byte count out of range");

    a_no_output_without_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_kind)))
        else $error("stalled result word lost or overwritten");
`endif

endmodule

`default_nettype wire
